### hdl/lpx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpx_pkg;

    // Header layout: header and sample sizes in bytes, position counter width
    localparam int unsigned HDR_BYTES    = 10;
    localparam int unsigned SAMPLE_BYTES = 3;
    localparam int unsigned POS_W        = 10;

    localparam logic [POS_W-1:0] POS_MAX  = 10'd1023;
    localparam logic [15:0]      HDR_MAGIC = 16'h55AA;

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_SHORT_HDR   = 2'd1;
    localparam logic [1:0] STATUS_SHORT_SAMPS = 2'd2;

    // One input transaction
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       first_of_buffer;
        logic       last_of_buffer;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic [15:0] computed_checksum;
        logic [15:0] received_checksum;
        logic        checksum_match;
        logic        header_word_ok;
        logic [1:0]  status;
        logic [7:0]  announced_count;
    } result_t;

endpackage

`default_nettype wire

### hdl/lidar_packet_xor16_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  packet_byte, first_of_buffer, last_of_buffer
// m_        out        m_valid / m_ready  checksums, match, header flag, status, count
//
// One byte per clock sustained unless a last byte waits on a full result register;
// a byte passes an input register, then combinational header/sample decode and
// XOR update; a last byte's result lands in the result register, raising m_valid.
// Synchronous active-low reset clears all buffer state and both valid flags;
// s_ready is low while reset is held.
// A waiting result stalls a following last byte in the input register, and all bytes behind it.
module lidar_packet_xor16_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_packet_byte,
    input  wire logic        s_first_of_buffer,
    input  wire logic        s_last_of_buffer,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_computed_checksum,
    output logic [15:0]      m_received_checksum,
    output logic             m_checksum_match,
    output logic             m_header_word_ok,
    output logic [1:0]       m_status,
    output logic [7:0]       m_announced_count
);

    lpx_pkg::item_t   in_item;
    lpx_pkg::item_t   item;
    lpx_pkg::result_t result;
    lpx_pkg::result_t out_res;
    logic             item_valid;
    logic             item_take;
    logic             res_free;
    logic             res_load;

    assign in_item.packet_byte     = s_packet_byte;
    assign in_item.first_of_buffer = s_first_of_buffer;
    assign in_item.last_of_buffer  = s_last_of_buffer;

    // Byte is processed unless it produces a result and the result slot is busy
    assign item_take = item_valid && (res_free || !item.last_of_buffer);
    assign res_load  = item_take && item.last_of_buffer;

    lpx_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    lpx_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .item_take (item_take),
        .result    (result)
    );

    lpx_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_load  (res_load),
        .res_in    (result),
        .res_free  (res_free),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_computed_checksum = out_res.computed_checksum;
    assign m_received_checksum = out_res.received_checksum;
    assign m_checksum_match    = out_res.checksum_match;
    assign m_header_word_ok    = out_res.header_word_ok;
    assign m_status            = out_res.status;
    assign m_announced_count   = out_res.announced_count;

endmodule

`default_nettype wire

### hdl/lpx_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lpx_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lpx_pkg::item_t in_item,
    output logic               item_valid,
    output lpx_pkg::item_t     item,
    input  wire logic          item_take
);

    logic           valid_reg;
    logic           valid_next;
    lpx_pkg::item_t item_reg;

    // Register is free when empty or its content is consumed this cycle; closed in reset
    assign in_ready   = aresetn && (!valid_reg || item_take);
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### hdl/lpx_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module lpx_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire lpx_pkg::item_t item,
    input  wire logic           item_take,
    output lpx_pkg::result_t    result
);

    localparam int unsigned PW = lpx_pkg::POS_W;

    // Header byte offsets
    localparam logic [3:0] HP_MAGIC_LO = 4'd0;
    localparam logic [3:0] HP_MAGIC_HI = 4'd1;
    localparam logic [3:0] HP_COUNT    = 4'd3;
    localparam logic [3:0] HP_START_HI = 4'd5;
    localparam logic [3:0] HP_END_HI   = 4'd7;
    localparam logic [3:0] HP_CSUM_LO  = 4'd8;
    localparam logic [3:0] HP_CSUM_HI  = 4'd9;

    localparam logic [PW-1:0] HDR_LEN = PW'(lpx_pkg::HDR_BYTES);

    logic [PW-1:0] pos_reg,   pos_next,   pos_cur;
    logic [15:0]   acc_reg,   acc_next,   acc_cur;
    logic [7:0]    held_reg,  held_next,  held_cur;
    logic [7:0]    ann_reg,   ann_next,   ann_cur;
    logic [15:0]   csum_reg,  csum_next,  csum_cur;
    logic [15:0]   hdr_reg,   hdr_next,   hdr_cur;
    // position within a sample, 0..2, advances with each byte past the header
    logic [1:0]    phase_reg, phase_next, phase_cur;

    logic [15:0]   word;
    logic [PW-1:0] samp_bytes;
    logic [PW-1:0] samp_off;
    logic          in_samples;
    logic [1:0]    status;

    // Byte update: first mark clears state before use
    always_comb begin
        pos_cur   = item.first_of_buffer ? '0 : pos_reg;
        acc_cur   = item.first_of_buffer ? '0 : acc_reg;
        held_cur  = item.first_of_buffer ? '0 : held_reg;
        ann_cur   = item.first_of_buffer ? '0 : ann_reg;
        csum_cur  = item.first_of_buffer ? '0 : csum_reg;
        hdr_cur   = item.first_of_buffer ? '0 : hdr_reg;
        phase_cur = item.first_of_buffer ? '0 : phase_reg;

        word       = {item.packet_byte, held_cur};
        samp_bytes = {1'b0, ann_cur, 1'b0} + {2'b00, ann_cur};
        samp_off   = pos_cur - HDR_LEN;
        in_samples = (samp_off < samp_bytes);

        acc_next   = acc_cur;
        held_next  = held_cur;
        ann_next   = ann_cur;
        csum_next  = csum_cur;
        hdr_next   = hdr_cur;
        phase_next = phase_cur;

        if (pos_cur < HDR_LEN) begin
            case (pos_cur[3:0])
                HP_MAGIC_LO: begin
                    hdr_next  = {8'h00, item.packet_byte};
                    held_next = item.packet_byte;
                end
                HP_MAGIC_HI: begin
                    hdr_next = word;
                    acc_next = acc_cur ^ word;
                end
                HP_COUNT: begin
                    ann_next = item.packet_byte;
                    acc_next = acc_cur ^ word;
                end
                HP_START_HI, HP_END_HI: begin
                    acc_next = acc_cur ^ word;
                end
                HP_CSUM_LO: begin
                    csum_next = {8'h00, item.packet_byte};
                end
                HP_CSUM_HI: begin
                    csum_next = {item.packet_byte, csum_cur[7:0]};
                end
                default: begin
                    held_next = item.packet_byte;
                end
            endcase
        end else begin
            phase_next = (phase_cur == 2'd2) ? 2'd0 : phase_cur + 2'd1;
            if (in_samples) begin
                case (phase_cur)
                    2'd0:    acc_next  = acc_cur ^ {8'h00, item.packet_byte};
                    2'd1:    held_next = item.packet_byte;
                    default: acc_next  = acc_cur ^ word;
                endcase
            end
        end

        pos_next = (pos_cur < lpx_pkg::POS_MAX) ? pos_cur + 1'b1 : pos_cur;
    end

    // Result fields from the updated state
    always_comb begin
        if (pos_next < HDR_LEN) begin
            status = lpx_pkg::STATUS_SHORT_HDR;
        end else if ((pos_next - HDR_LEN) < samp_bytes) begin
            status = lpx_pkg::STATUS_SHORT_SAMPS;
        end else begin
            status = lpx_pkg::STATUS_OK;
        end

        result.computed_checksum = acc_next;
        result.received_checksum = csum_next;
        result.checksum_match    = (status == lpx_pkg::STATUS_OK) && (acc_next == csum_next);
        result.header_word_ok    = (hdr_next == lpx_pkg::HDR_MAGIC);
        result.status            = status;
        result.announced_count   = ann_next;
    end

    // State registers; cleared after the last byte of a buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            acc_reg   <= '0;
            held_reg  <= '0;
            ann_reg   <= '0;
            csum_reg  <= '0;
            hdr_reg   <= '0;
            phase_reg <= '0;
        end else if (item_take) begin
            if (item.last_of_buffer) begin
                pos_reg   <= '0;
                acc_reg   <= '0;
                held_reg  <= '0;
                ann_reg   <= '0;
                csum_reg  <= '0;
                hdr_reg   <= '0;
                phase_reg <= '0;
            end else begin
                pos_reg   <= pos_next;
                acc_reg   <= acc_next;
                held_reg  <= held_next;
                ann_reg   <= ann_next;
                csum_reg  <= csum_next;
                hdr_reg   <= hdr_next;
                phase_reg <= phase_next;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/lpx_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lpx_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             res_load,
    input  wire lpx_pkg::result_t res_in,
    output logic                  res_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lpx_pkg::result_t      out_res
);

    logic             valid_reg;
    logic             valid_next;
    lpx_pkg::result_t res_reg;

    // Free when empty or being drained this cycle
    assign res_free   = !valid_reg || out_ready;
    assign valid_next = res_load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire
